@@ rtl/dollar_comma_star_message_framer_macros.svh @@
// Assertion macros used by the framer checker.
`ifndef DOLLAR_COMMA_STAR_MESSAGE_FRAMER_MACROS_SVH
`define DOLLAR_COMMA_STAR_MESSAGE_FRAMER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define DCSMF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define DCSMF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/dcsmf_pkg.sv @@
package dcsmf_pkg;

   // Default store depths
   localparam int unsigned DCSMF_TYPE_MAX    = 6;
   localparam int unsigned DCSMF_PAYLOAD_MAX = 12;

   // Byte lanes of the result fields
   localparam int unsigned TYPE_FIELD_BYTES    = 6;
   localparam int unsigned PAYLOAD_LOW_BYTES   = 8;
   localparam int unsigned PAYLOAD_FIELD_BYTES = 12;

   // Framing characters
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_STAR   = 8'h2A;

   typedef enum logic [2:0] {
      PH_HUNT    = 3'b001,
      PH_TYPE    = 3'b010,
      PH_PAYLOAD = 3'b100
   } phase_type;

   typedef struct packed {
      logic [47:0] type_chars;
      logic [2:0]  type_length;
      logic [63:0] payload_chars_low;
      logic [31:0] payload_chars_high;
      logic [3:0]  payload_length;
   } result_type;

   // Finished frame handed from the parser to the result register
   typedef struct packed {
      logic       valid;
      result_type data;
   } handoff_type;

endpackage

@@ rtl/dcsmf_in_stage.sv @@
module dcsmf_in_stage
   import dcsmf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_rx_byte,
   input  logic       out_free,
   output logic       fire,
   output logic [7:0] rx_byte
);

   logic       valid_ff;
   logic       valid_in;
   logic [7:0] byte_ff;

   assign fire      = valid_ff && out_free;
   assign req_ready = !valid_ff || out_free;
   assign rx_byte   = byte_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_valid && req_ready) begin
         valid_in = 1'b1;
      end else if (fire) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         byte_ff <= req_rx_byte;
      end
   end

endmodule

@@ rtl/dcsmf_parser.sv @@
module dcsmf_parser
   import dcsmf_pkg::*;
#(
   parameter int unsigned TypeMax    = DCSMF_TYPE_MAX,
   parameter int unsigned PayloadMax = DCSMF_PAYLOAD_MAX
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        fire,
   input  logic [7:0]  rx_byte,
   output handoff_type frame
);

   localparam int unsigned TCW = $clog2(TypeMax + 1);
   localparam int unsigned PCW = $clog2(PayloadMax + 1);
   localparam int unsigned TIW = (TypeMax > 1) ? $clog2(TypeMax) : 1;
   localparam int unsigned PIW = (PayloadMax > 1) ? $clog2(PayloadMax) : 1;

   phase_type        phase_ff, phase_in;
   logic [TCW-1:0]   type_count_ff, type_count_in;
   logic [PCW-1:0]   payload_count_ff, payload_count_in;
   logic [7:0]       type_store_ff [TypeMax];
   logic [7:0]       payload_store_ff [PayloadMax];

   logic             type_we;
   logic             payload_we;
   logic             emit;
   logic [PCW-1:0]   emit_plen;

   logic [TYPE_FIELD_BYTES-1:0][7:0]    type_bytes;
   logic [PAYLOAD_FIELD_BYTES-1:0][7:0] payload_bytes;

   always_comb begin
      phase_in         = phase_ff;
      type_count_in    = type_count_ff;
      payload_count_in = payload_count_ff;
      type_we          = 1'b0;
      payload_we       = 1'b0;
      emit             = 1'b0;
      emit_plen        = '0;
      unique case (phase_ff)
         PH_TYPE: begin
            priority if (rx_byte == CH_COMMA) begin
               phase_in         = PH_PAYLOAD;
               payload_count_in = '0;
            end else if (rx_byte == CH_STAR) begin
               // star inside the type: empty payload
               payload_count_in = '0;
               emit             = 1'b1;
               phase_in         = PH_HUNT;
            end else if (type_count_ff >= TCW'(TypeMax)) begin
               phase_in      = PH_HUNT;
               type_count_in = '0;
            end else begin
               type_we       = 1'b1;
               type_count_in = type_count_ff + 1'b1;
            end
         end
         PH_PAYLOAD: begin
            priority if (rx_byte == CH_STAR) begin
               emit      = 1'b1;
               emit_plen = payload_count_ff;
               phase_in  = PH_HUNT;
            end else if (payload_count_ff >= PCW'(PayloadMax)) begin
               phase_in         = PH_HUNT;
               payload_count_in = '0;
            end else begin
               payload_we       = 1'b1;
               payload_count_in = payload_count_ff + 1'b1;
            end
         end
         default: begin
            phase_in = PH_HUNT;
            if (rx_byte == CH_DOLLAR) begin
               phase_in         = PH_TYPE;
               type_count_in    = '0;
               payload_count_in = '0;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HUNT;
         type_count_ff    <= '0;
         payload_count_ff <= '0;
      end else if (fire) begin
         phase_ff         <= phase_in;
         type_count_ff    <= type_count_in;
         payload_count_ff <= payload_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire && type_we) begin
         type_store_ff[type_count_ff[TIW-1:0]] <= rx_byte;
      end
      if (fire && payload_we) begin
         payload_store_ff[payload_count_ff[PIW-1:0]] <= rx_byte;
      end
   end

   // Zero every byte past the valid length
   for (genvar k = 0; k < TYPE_FIELD_BYTES; k++) begin : g_type
      if (k < TypeMax) begin : g_used
         assign type_bytes[k] = (TCW'(k) < type_count_ff) ? type_store_ff[k] : 8'h00;
      end else begin : g_unused
         assign type_bytes[k] = 8'h00;
      end
   end

   for (genvar k = 0; k < PAYLOAD_FIELD_BYTES; k++) begin : g_payload
      if (k < PayloadMax) begin : g_used
         assign payload_bytes[k] = (PCW'(k) < emit_plen) ? payload_store_ff[k] : 8'h00;
      end else begin : g_unused
         assign payload_bytes[k] = 8'h00;
      end
   end

   assign frame.valid                   = fire && emit;
   assign frame.data.type_chars         = type_bytes;
   assign frame.data.type_length        = 3'(type_count_ff);
   assign frame.data.payload_chars_low  = payload_bytes[PAYLOAD_LOW_BYTES-1:0];
   assign frame.data.payload_chars_high =
      payload_bytes[PAYLOAD_FIELD_BYTES-1:PAYLOAD_LOW_BYTES];
   assign frame.data.payload_length     = 4'(emit_plen);

endmodule

@@ rtl/dcsmf_out_stage.sv @@
module dcsmf_out_stage
   import dcsmf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  handoff_type frame,
   output logic        out_free,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output result_type  rsp_data
);

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   assign out_free  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (frame.valid) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (frame.valid) begin
         data_ff <= frame.data;
      end
   end

endmodule

@@ rtl/dollar_comma_star_message_framer.sv @@
// Message framer for $TYPE,PAYLOAD* streams.
// Request channel (req_valid/req_ready/req_rx_byte): one received character per
// request. Bytes are dropped until '$'; up to TypeMax type characters follow
// until ',', then up to PayloadMax payload characters until '*'. A character
// that arrives with its store full drops the frame silently; a '*' inside the
// type ends the frame with an empty payload.
// Response channel (rsp_*): one response per '*' that ends a frame, with the
// characters packed first-in-low-byte, unused bytes zero, and the two lengths.
// Path: a '*' request is captured in the input register, then parsed into
// the result register, which raises rsp_valid; the parse waits while a
// response is held.
// Throughput: one request per cycle while responses are taken; the per-byte
// parse is a single pass of logic between those two registers.
// Stall: while a response waits, the input register still takes one request;
// it parses it once the result register frees, so req_ready drops only when
// both registers hold data.
// Reset (synchronous, active high): empty both registers and return to
// hunting for '$'. Character stores are not cleared; only valid entries are
// ever shown.
module dollar_comma_star_message_framer
   import dcsmf_pkg::*;
#(
   parameter int unsigned TypeMax    = DCSMF_TYPE_MAX,
   parameter int unsigned PayloadMax = DCSMF_PAYLOAD_MAX
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [47:0] rsp_type_chars,
   output logic [2:0]  rsp_type_length,
   output logic [63:0] rsp_payload_chars_low,
   output logic [31:0] rsp_payload_chars_high,
   output logic [3:0]  rsp_payload_length
);

   logic        out_free;
   logic        fire;
   logic [7:0]  rx_byte;
   handoff_type frame;
   result_type  rsp_data;

   // Hold the accepted byte until the result side can take its outcome
   dcsmf_in_stage u_in_stage (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .out_free    (out_free),
      .fire        (fire),
      .rx_byte     (rx_byte)
   );

   // Advance the framing state and build a finished frame on '*'
   dcsmf_parser #(
      .TypeMax    (TypeMax),
      .PayloadMax (PayloadMax)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .rx_byte (rx_byte),
      .frame   (frame)
   );

   // Hold the response until the receiver takes it
   dcsmf_out_stage u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .frame     (frame),
      .out_free  (out_free),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_type_chars         = rsp_data.type_chars;
   assign rsp_type_length        = rsp_data.type_length;
   assign rsp_payload_chars_low  = rsp_data.payload_chars_low;
   assign rsp_payload_chars_high = rsp_data.payload_chars_high;
   assign rsp_payload_length     = rsp_data.payload_length;

endmodule

@@ rtl/dcsmf_checker.sv @@
`include "dollar_comma_star_message_framer_macros.svh"

module dcsmf_checker
   import dcsmf_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [47:0] rsp_type_chars,
   input logic [2:0]  rsp_type_length,
   input logic [63:0] rsp_payload_chars_low,
   input logic [31:0] rsp_payload_chars_high,
   input logic [3:0]  rsp_payload_length
);

   logic         req_fire;
   logic [150:0] rsp_bundle;
   logic         len_ok;

   assign req_fire   = req_valid && req_ready;
   assign rsp_bundle = {rsp_type_chars, rsp_type_length, rsp_payload_chars_low,
                        rsp_payload_chars_high, rsp_payload_length};
   assign len_ok     = (rsp_type_length <= 3'(DCSMF_TYPE_MAX)) &&
                       (rsp_payload_length <= 4'(DCSMF_PAYLOAD_MAX));

   `DCSMF_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(rsp_bundle), "response changed while stalled")
   `DCSMF_ASSERT_IMPL(a_len_bound, clock, reset, rsp_valid, len_ok,
      "length out of range")
   `DCSMF_ASSERT_IMPL(a_empty_type, clock, reset, rsp_valid && rsp_type_length == 3'd0,
      rsp_type_chars == 48'd0, "empty type with nonzero characters")
   `DCSMF_ASSERT_IMPL(a_short_payload, clock, reset,
      rsp_valid && rsp_payload_length <= 4'd8, rsp_payload_chars_high == 32'd0,
      "short payload with nonzero high bytes")
   `DCSMF_ASSERT_IMPL(a_rsp_after_req, clock, reset, $rose(rsp_valid), $past(req_fire, 2),
      "response without a request two cycles before")

endmodule

bind dollar_comma_star_message_framer dcsmf_checker u_checker (.*);
